// ===== hw/rtl/pis_pkg.sv =====
package pis_pkg;

   // Default sizes
   localparam int DEF_MAX_INTERVALS = 256;
   localparam int DEF_MAX_RESOURCES = 16;

   // Field widths
   localparam int TIME_W = 16;
   localparam int RIDX_W = 5;
   localparam int CNT_W  = 9;
   localparam int CFG_W  = 5;
   localparam int LIM_W  = 9;   // holds any resource limit up to 256

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;

   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [RIDX_W-1:0] resource_index;
      logic              last_item;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] accepted_count;
      logic             bad_index_seen;
      logic             overflow_seen;
   } rsp_type;

   // One buffered interval
   typedef struct packed {
      logic [TIME_W-1:0] end_time;
      logic [TIME_W-1:0] start_time;
      logic [RIDX_W-1:0] resource_index;
   } entry_type;

   typedef struct packed {
      logic commit;
      logic clear_set;
   } sel_ctrl_type;

   typedef struct packed {
      logic found;
      logic idle;
   } sel_stat_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_DRAIN,
      ST_COMMIT,
      ST_REPORT
   } state_type;

endpackage

// ===== hw/rtl/pis_store.sv =====
module pis_store #(
   parameter int DEPTH = pis_pkg::DEF_MAX_INTERVALS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pis_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic                rd_valid,
   output logic [AW-1:0]       rd_addr_q,
   output pis_pkg::entry_type  rd_data
);
   import pis_pkg::*;

   entry_type       mem [DEPTH];
   logic            rd_valid_ff;
   logic [AW-1:0]   rd_addr_ff;
   entry_type       rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid  = rd_valid_ff;
   assign rd_addr_q = rd_addr_ff;
   assign rd_data   = rd_data_ff;

endmodule

// ===== hw/rtl/pis_select.sv =====
module pis_select #(
   parameter int MAX_INTERVALS = pis_pkg::DEF_MAX_INTERVALS,
   parameter int MAX_RESOURCES = pis_pkg::DEF_MAX_RESOURCES,
   parameter int AW            = $clog2(MAX_INTERVALS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [AW-1:0]          in_addr,
   input  pis_pkg::entry_type     in_data,
   input  pis_pkg::sel_ctrl_type  ctrl,
   output pis_pkg::sel_stat_type  stat
);
   import pis_pkg::*;

   localparam int TBL_DEPTH = ((MAX_RESOURCES < 31) ? MAX_RESOURCES : 31) + 1;
   localparam int TBL_W     = $clog2(TBL_DEPTH);
   localparam int KEY_W     = 2 * TIME_W + AW;

   // Per-resource state
   logic                 busy_ff     [TBL_DEPTH];
   logic [TIME_W-1:0]    last_end_ff [TBL_DEPTH];

   // Cursor: key of the most recent accepted interval
   logic                 cur_vld_ff;
   logic [KEY_W-1:0]     cursor_ff;

   // Eligibility stage
   logic                 b_vld_ff,  b_vld_in;
   logic [KEY_W-1:0]     b_key_ff;
   logic [TBL_W-1:0]     b_r_ff;

   // Running minimum
   logic                 found_ff;
   logic [KEY_W-1:0]     best_key_ff;
   logic [TBL_W-1:0]     best_r_ff;

   logic [TBL_W-1:0]     in_r;
   logic [KEY_W-1:0]     in_key;
   logic                 res_free;
   logic                 after_cursor;
   logic                 take_best;

   assign in_r   = in_data.resource_index[TBL_W-1:0];
   assign in_key = {in_data.end_time, in_data.start_time, in_addr};

   always_comb begin
      res_free     = !busy_ff[in_r] || (last_end_ff[in_r] <= in_data.start_time);
      after_cursor = !cur_vld_ff || (in_key > cursor_ff);
      b_vld_in     = in_valid && res_free && after_cursor;
      take_best    = b_vld_ff && (!found_ff || (b_key_ff < best_key_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         found_ff   <= 1'b0;
         cur_vld_ff <= 1'b0;
         for (int i = 0; i < TBL_DEPTH; i++) begin
            busy_ff[i] <= 1'b0;
         end
      end else begin
         b_vld_ff <= b_vld_in;
         if (ctrl.clear_set) begin
            found_ff   <= 1'b0;
            cur_vld_ff <= 1'b0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
               busy_ff[i] <= 1'b0;
            end
         end else if (ctrl.commit) begin
            found_ff <= 1'b0;
            if (found_ff) begin
               cur_vld_ff         <= 1'b1;
               busy_ff[best_r_ff] <= 1'b1;
            end
         end else if (take_best) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      b_key_ff <= in_key;
      b_r_ff   <= in_r;
      if (take_best) begin
         best_key_ff <= b_key_ff;
         best_r_ff   <= b_r_ff;
      end
      if (ctrl.commit && found_ff) begin
         cursor_ff              <= best_key_ff;
         last_end_ff[best_r_ff] <= best_key_ff[KEY_W-1 -: TIME_W];
      end
   end

   assign stat.found = found_ff;
   assign stat.idle  = !in_valid && !b_vld_ff;

endmodule

// ===== hw/rtl/per_platform_interval_scheduler.sv =====
// Per-platform interval scheduler: greedy activity selection with one lane
// per resource (platform).
// Input channel: an item (start_time, end_time, resource_index, last_item)
// is taken on a clock edge where start is high and busy is low. Items of a
// set load one per cycle. An item naming an index above the configured
// resource count (capped at MAX_RESOURCES) is not stored and sets the bad
// index flag; an item arriving with the buffer full is dropped and sets the
// overflow flag.
// After the item with last_item set, busy rises and the block repeatedly
// scans the buffer with one shared compare unit: each pass reads every
// stored interval (one memory read per cycle) and picks the smallest
// (end, start, position) key that follows the last accepted one and fits
// its resource. There are accepted + 1 passes per set.
// Result channel: rsp_valid pulses for one cycle with rsp_item; it cannot
// be held off, and busy falls in that same cycle.
// Configuration: csr_we writes csr_wdata as the resource count; write it
// only while the block is idle. Reset sets the count to 16 and empties the
// current set; no memory clearing pass is needed.
module per_platform_interval_scheduler #(
   parameter int MAX_INTERVALS = pis_pkg::DEF_MAX_INTERVALS,
   parameter int MAX_RESOURCES = pis_pkg::DEF_MAX_RESOURCES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  pis_pkg::req_type            req_item,
   output logic                        rsp_valid,
   output pis_pkg::rsp_type            rsp_item,
   input  logic                        csr_we,
   input  logic [pis_pkg::CFG_W-1:0]   csr_wdata
);
   import pis_pkg::*;

   localparam int AW = $clog2(MAX_INTERVALS);
   localparam logic [AW:0]      DEPTH_V   = (AW+1)'(MAX_INTERVALS);
   localparam logic [LIM_W-1:0] MAX_RES_V = LIM_W'(MAX_RESOURCES);

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     resource_count_ff;
   logic [AW:0]          load_cnt_ff, load_cnt_in;   // stored intervals
   logic [AW:0]          rd_cnt_ff,   rd_cnt_in;     // scan read pointer
   logic                 bad_ff, bad_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_item_ff,  rsp_item_in;

   logic                 bad_index;
   logic                 wr_en;
   logic                 rd_en;
   entry_type            wr_data;
   logic                 st_rd_valid;
   logic [AW-1:0]        st_rd_addr;
   entry_type            st_rd_data;
   sel_ctrl_type         sel_ctrl;
   sel_stat_type         sel_stat;

   // Index check: above the configured count or above MAX_RESOURCES
   assign bad_index = (req_item.resource_index > resource_count_ff) ||
                      (LIM_W'(req_item.resource_index) > MAX_RES_V);

   assign wr_data.end_time       = req_item.end_time;
   assign wr_data.start_time     = req_item.start_time;
   assign wr_data.resource_index = req_item.resource_index;

   // Interval buffer
   pis_store #(
      .DEPTH (MAX_INTERVALS),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (load_cnt_ff[AW-1:0]),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_cnt_ff[AW-1:0]),
      .rd_valid  (st_rd_valid),
      .rd_addr_q (st_rd_addr),
      .rd_data   (st_rd_data)
   );

   // Shared compare unit with the per-resource table
   pis_select #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .MAX_RESOURCES (MAX_RESOURCES),
      .AW            (AW)
   ) u_select (
      .clock    (clock),
      .reset    (reset),
      .in_valid (st_rd_valid),
      .in_addr  (st_rd_addr),
      .in_data  (st_rd_data),
      .ctrl     (sel_ctrl),
      .stat     (sel_stat)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      rd_cnt_in    = rd_cnt_ff;
      bad_in       = bad_ff;
      ovf_in       = ovf_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      sel_ctrl     = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (start) begin
               if (bad_index) begin
                  bad_in = 1'b1;
               end
               // Drop when full, otherwise store valid intervals
               if (load_cnt_ff == DEPTH_V) begin
                  ovf_in = 1'b1;
               end else if (!bad_index) begin
                  wr_en       = 1'b1;
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
               if (req_item.last_item) begin
                  rd_cnt_in = '0;
                  state_in  = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            // Read each stored interval once per pass
            if (rd_cnt_ff == load_cnt_ff) begin
               state_in = ST_DRAIN;
            end else begin
               rd_en     = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // Wait for the last read to reach the running minimum
            if (sel_stat.idle) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // Accept the pass winner, or finish when nothing fits
            sel_ctrl.commit = 1'b1;
            if (sel_stat.found) begin
               if (acc_ff != CNT_MAX) begin
                  acc_in = acc_ff + 1'b1;
               end
               rd_cnt_in = '0;
               state_in  = ST_PASS;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            rsp_valid_in                = 1'b1;
            rsp_item_in.accepted_count  = acc_ff;
            rsp_item_in.bad_index_seen  = bad_ff;
            rsp_item_in.overflow_seen   = ovf_ff;
            // Clear the set for the next one
            sel_ctrl.clear_set = 1'b1;
            load_cnt_in        = '0;
            bad_in             = 1'b0;
            ovf_in             = 1'b0;
            acc_in             = '0;
            state_in           = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_LOAD;
         resource_count_ff <= CFG_RESET;
         load_cnt_ff       <= '0;
         rd_cnt_ff         <= '0;
         bad_ff            <= 1'b0;
         ovf_ff            <= 1'b0;
         acc_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         bad_ff       <= bad_in;
         ovf_ff       <= ovf_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            resource_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== dv/per_platform_interval_scheduler_test.sv =====
`timescale 1ns / 100ps

module per_platform_interval_scheduler_test;
   import pis_pkg::*;

   // Watchdog: the slowest legal set is 256 stored, all granted; allow several
   // times what it needs after its last item.
   localparam int STALL_LIMIT   = 400000;
   // Idle cycles required before a resource count write.
   localparam int SETTLE_CYCLES = 4;
   // Cycles to watch for stray reports once everything is in.
   localparam int DRAIN_CYCLES  = 60;
   localparam int SET_DEPTH     = DEF_MAX_INTERVALS;
   localparam int LANE_COUNT    = DEF_MAX_RESOURCES + 1;

   typedef enum logic {
      OP_INTERVAL,
      OP_LIMIT
   } plan_kind_type;

   // One step of the stimulus plan: either an interval item or a write of
   // the resource count.
   typedef struct packed {
      plan_kind_type    kind;
      req_type          item;
      logic [CFG_W-1:0] limit;
      logic [6:0]       gap_pct;
      logic             hold;
   } plan_entry_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_type          req_item  = '0;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_we    = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   plan_entry_type stim_plan[$];
   rsp_type        due_reports[$];

   // Shadow of the scheduler: the current set and the resource count.
   logic [TIME_W-1:0] set_start[SET_DEPTH];
   logic [TIME_W-1:0] set_end[SET_DEPTH];
   logic [RIDX_W-1:0] set_index[SET_DEPTH];
   int                set_size      = 0;
   logic              saw_bad       = 1'b0;
   logic              saw_overflow  = 1'b0;
   logic [CFG_W-1:0]  model_limit   = CFG_RESET;

   logic item_taken     = 1'b0;
   int   quiet_cycles   = 0;
   int   stall_cycles   = 0;
   int   mismatch_count = 0;

   per_platform_interval_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Greedy per-lane selection over the buffered set: order by departure,
   // then arrival (stable on position), grant when the lane is free or its
   // last granted departure is at or before the arrival.
   function automatic int count_granted();
      int                rank[SET_DEPTH];
      logic              lane_used[LANE_COUNT];
      logic [TIME_W-1:0] lane_end[LANE_COUNT];
      int                i, j, k, lane, granted;
      granted = 0;
      for (i = 0; i < LANE_COUNT; i++) begin
         lane_used[i] = 1'b0;
         lane_end[i]  = '0;
      end
      for (i = 0; i < set_size; i++) begin
         j = i;
         while (j > 0 && {set_end[i], set_start[i]} <
                         {set_end[rank[j-1]], set_start[rank[j-1]]}) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = i;
      end
      for (i = 0; i < set_size; i++) begin
         k    = rank[i];
         lane = int'(set_index[k]);
         if (lane < LANE_COUNT &&
             (!lane_used[lane] || lane_end[lane] <= set_start[k])) begin
            lane_used[lane] = 1'b1;
            lane_end[lane]  = set_end[k];
            granted++;
         end
      end
      if (granted > CNT_MAX)
         granted = int'(CNT_MAX);
      return granted;
   endfunction

   // Take one accepted interval into the shadow set; on the last item of
   // a set, queue the report it must produce and clear the set.
   function automatic void absorb_interval(req_type it);
      int      cap;
      logic    bad;
      rsp_type report;
      cap = (model_limit > DEF_MAX_RESOURCES) ? DEF_MAX_RESOURCES : model_limit;
      bad = (it.resource_index > cap);
      if (bad)
         saw_bad = 1'b1;
      if (set_size >= SET_DEPTH) begin
         saw_overflow = 1'b1;
      end else if (!bad) begin
         set_start[set_size] = it.start_time;
         set_end[set_size]   = it.end_time;
         set_index[set_size] = it.resource_index;
         set_size++;
      end
      if (it.last_item) begin
         report.accepted_count = CNT_W'(count_granted());
         report.bad_index_seen = saw_bad;
         report.overflow_seen  = saw_overflow;
         due_reports.push_back(report);
         set_size     = 0;
         saw_bad      = 1'b0;
         saw_overflow = 1'b0;
      end
   endfunction

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch: %s", $time, what);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present items and resource count writes from the plan.
   // Inputs change on the falling edge only.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive
      plan_entry_type   head;
      logic             nxt_start;
      logic             nxt_we;
      req_type          nxt_req;
      logic [CFG_W-1:0] nxt_wdata;
      nxt_start = start;
      nxt_req   = req_item;
      nxt_we    = 1'b0;
      nxt_wdata = csr_wdata;
      // Count how long the block has been fully idle; register writes
      // wait for a few such cycles.
      if (!start && !busy && due_reports.size() == 0)
         quiet_cycles++;
      else
         quiet_cycles = 0;
      if (reset) begin
         nxt_start = 1'b0;
      end else begin
         // Drop start once the item on the port has been taken.
         if (start && item_taken)
            nxt_start = 1'b0;
         if (!nxt_start && stim_plan.size() != 0) begin
            head = stim_plan[0];
            if (head.kind == OP_LIMIT) begin
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  void'(stim_plan.pop_front());
                  nxt_we       = 1'b1;
                  nxt_wdata    = head.limit;
                  model_limit  = head.limit;
                  quiet_cycles = 0;
               end
            end else if (head.hold && (due_reports.size() != 0 || busy)) begin
               // Hold off until every outstanding report has come back.
            end else if ($urandom_range(0, 99) >= head.gap_pct) begin
               void'(stim_plan.pop_front());
               nxt_start = 1'b1;
               nxt_req   = head.item;
            end
         end
      end
      start     <= nxt_start;
      req_item  <= nxt_req;
      csr_we    <= nxt_we;
      csr_wdata <= nxt_wdata;
   end

   // ---------------------------------------------------------------------
   // Monitor: sample on the rising edge, check reports, predict on every
   // accepted item, and run the watchdog.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : observe
      rsp_type want;
      logic    progress;
      progress   = 1'b0;
      item_taken = 1'b0;
      if (reset) begin
         set_size     = 0;
         saw_bad      = 1'b0;
         saw_overflow = 1'b0;
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            progress = 1'b1;
            if (due_reports.size() == 0) begin
               note_mismatch($sformatf("report with none due: count %0d bad %0b ovf %0b",
                                       rsp_item.accepted_count, rsp_item.bad_index_seen,
                                       rsp_item.overflow_seen));
            end else begin
               want = due_reports.pop_front();
               if (rsp_item.accepted_count !== want.accepted_count)
                  note_mismatch($sformatf("accepted_count expected %0d got %0d",
                                          want.accepted_count, rsp_item.accepted_count));
               if (rsp_item.bad_index_seen !== want.bad_index_seen)
                  note_mismatch($sformatf("bad_index_seen expected %0b got %0b",
                                          want.bad_index_seen, rsp_item.bad_index_seen));
               if (rsp_item.overflow_seen !== want.overflow_seen)
                  note_mismatch($sformatf("overflow_seen expected %0b got %0b",
                                          want.overflow_seen, rsp_item.overflow_seen));
            end
         end
         if (start && !busy) begin
            item_taken = 1'b1;
            progress   = 1'b1;
            absorb_interval(req_item);
         end
         if (progress)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("per_platform_interval_scheduler verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus plan
   // ---------------------------------------------------------------------
   function automatic void plan_interval(logic [TIME_W-1:0] st, logic [TIME_W-1:0] en,
                                         logic [RIDX_W-1:0] ri, logic last,
                                         int gap, logic hold);
      plan_entry_type e;
      e                     = '0;
      e.kind                = OP_INTERVAL;
      e.item.start_time     = st;
      e.item.end_time       = en;
      e.item.resource_index = ri;
      e.item.last_item      = last;
      e.gap_pct             = 7'(gap);
      e.hold                = hold;
      stim_plan.push_back(e);
   endfunction

   function automatic void plan_limit(logic [CFG_W-1:0] value);
      plan_entry_type e;
      e       = '0;
      e.kind  = OP_LIMIT;
      e.limit = value;
      stim_plan.push_back(e);
   endfunction

   // A well-formed set with random content: times packed into a window so
   // lanes contend, mostly valid indices, a few stray ones.
   function automatic void plan_set(int n, int cap, int gap, logic hold);
      logic [TIME_W-1:0] base, st, en;
      logic [RIDX_W-1:0] ri;
      int                span, i;
      base = TIME_W'($urandom);
      span = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(4, 300);
      for (i = 0; i < n; i++) begin
         st = base + TIME_W'($urandom_range(0, span));
         en = st + TIME_W'($urandom_range(0, span / 2));
         if ($urandom_range(0, 19) == 0)
            en = TIME_W'($urandom);
         if ($urandom_range(0, 11) == 0)
            ri = RIDX_W'($urandom_range(0, 31));
         else
            ri = RIDX_W'($urandom_range(0, cap));
         plan_interval(st, en, ri, i == n - 1, gap, hold && i == 0);
      end
   endfunction

   // Write the resource count, then fill the phase with random sets.
   function automatic void plan_phase(logic [CFG_W-1:0] limit, int gap, int budget);
      int cap, planned, n;
      cap     = (limit > DEF_MAX_RESOURCES) ? DEF_MAX_RESOURCES : limit;
      planned = 0;
      plan_limit(limit);
      while (planned < budget) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
         plan_set(n, cap, gap, planned == 0 || $urandom_range(0, 9) == 0);
         planned += n;
      end
   endfunction

   function automatic void plan_deep_sets();
      int i, k, offset;
      logic [TIME_W-1:0] st;
      // Fill the buffer exactly with disjoint intervals in scrambled order:
      // every one is granted, giving the largest count.
      offset = $urandom_range(0, 255);
      for (i = 0; i < SET_DEPTH; i++) begin
         k  = (i * 37 + offset) % SET_DEPTH;
         st = TIME_W'(k * 200 + $urandom_range(0, 99));
         plan_interval(st, st + TIME_W'($urandom_range(0, 100)),
                       RIDX_W'($urandom_range(0, DEF_MAX_RESOURCES)),
                       i == SET_DEPTH - 1, 0, i == 0);
      end
      // Overrun the buffer; one stray index arrives while it is full.
      for (i = 0; i < SET_DEPTH + 6; i++)
         plan_interval(TIME_W'($urandom), TIME_W'($urandom),
                       (i == SET_DEPTH + 2) ? RIDX_W'(31)
                                            : RIDX_W'($urandom_range(0, DEF_MAX_RESOURCES)),
                       i == SET_DEPTH + 5, 0, 1'b0);
   endfunction

   initial begin
      // Directed sets at the reset resource count of 16.
      plan_interval(16'h0000, 16'h0000, 5'd0, 1'b1, 0, 1'b1);
      // Extremes of time and index, a reversed interval, stray indices.
      plan_interval(16'hFFFF, 16'hFFFF, 5'd16, 1'b0, 0, 1'b0);
      plan_interval(16'h0000, 16'hFFFF, 5'd16, 1'b0, 0, 1'b0);
      plan_interval(16'd5,    16'd3,    5'd1,  1'b0, 0, 1'b0);
      plan_interval(16'd7,    16'd9,    5'd17, 1'b0, 0, 1'b0);
      plan_interval(16'd100,  16'd200,  5'd31, 1'b1, 0, 1'b0);
      // Touching, overlapping and identical intervals, mostly on one lane.
      plan_interval(16'd10, 16'd20, 5'd2, 1'b0, 0, 1'b0);
      plan_interval(16'd15, 16'd25, 5'd2, 1'b0, 0, 1'b0);
      plan_interval(16'd20, 16'd30, 5'd2, 1'b0, 0, 1'b0);
      plan_interval(16'd20, 16'd30, 5'd2, 1'b0, 0, 1'b0);
      plan_interval(16'd20, 16'd30, 5'd3, 1'b1, 0, 1'b0);
      // Equal departures broken by arrival, zero-length duplicates.
      plan_interval(16'd30, 16'd50, 5'd4, 1'b0, 0, 1'b0);
      plan_interval(16'd5,  16'd50, 5'd4, 1'b0, 0, 1'b0);
      plan_interval(16'd50, 16'd50, 5'd4, 1'b0, 0, 1'b0);
      plan_interval(16'd50, 16'd50, 5'd4, 1'b1, 0, 1'b0);
      // Lowest count: only lane 0 is valid.
      plan_limit(5'd0);
      plan_interval(16'd1, 16'd2, 5'd0, 1'b0, 0, 1'b0);
      plan_interval(16'd2, 16'd3, 5'd0, 1'b0, 0, 1'b0);
      plan_interval(16'd0, 16'd9, 5'd1, 1'b1, 0, 1'b0);
      // Highest code: capped at 16, so lanes 0 to 16 are valid.
      plan_limit(5'd31);
      plan_interval(16'd0, 16'd100, 5'd16, 1'b0, 0, 1'b0);
      plan_interval(16'd0, 16'd100, 5'd17, 1'b0, 0, 1'b0);
      plan_interval(16'd0, 16'd100, 5'd31, 1'b1, 0, 1'b0);

      // Random phases: back to back, sparse sender, moderate gaps, then
      // back to back again with the deep sets.
      plan_phase(5'd16, 0, 350);
      plan_phase(CFG_W'($urandom_range(1, 15)), 86, 350);
      plan_phase(5'd31, 31, 350);
      plan_phase(5'd16, 0, 250);
      plan_deep_sets();

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (stim_plan.size() != 0 || start || busy || due_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && due_reports.size() == 0)
         $display("per_platform_interval_scheduler verification clean");
      else
         $display("per_platform_interval_scheduler verification failed");
      $finish;
   end

endmodule
